@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define APF_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define APF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/apf_pkg.sv @@
// Package with the types, constants and register codes of the all-pole filter.
package apf_pkg;

  localparam int MAX_ORDER_DEF = 6;
  localparam int CHANNELS_DEF  = 64;
  localparam int NUM_COEF      = 6;
  localparam int SAMPLE_W      = 16;
  localparam int CHAN_W        = 6;
  localparam int ORDER_W       = 3;
  localparam int ACC_W         = 36;
  localparam int FRAC_SHIFT    = 13;
  localparam int TDATA_W       = 24;
  localparam int ADDR_W        = 5;
  localparam int PDATA_W       = 32;

  typedef logic signed [SAMPLE_W-1:0] coef_t;

  typedef enum logic [2:0] {
    REG_ORDER = 3'd0,
    REG_COEF1 = 3'd1,
    REG_COEF2 = 3'd2,
    REG_COEF3 = 3'd3,
    REG_COEF4 = 3'd4,
    REG_COEF5 = 3'd5,
    REG_COEF6 = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MAC,
    S_ROUND
  } state_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic rd;
    logic init;
    logic mac;
    logic finish;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic order_zero;
    logic tap_last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/apf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module apf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/apf_ctrl.sv @@
// Controller state machine that sequences the clearing pass and each sample.
module apf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  apf_pkg::sts_t sts,
  output apf_pkg::cmd_t cmd
);

  import apf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        state_next = sts.order_zero ? S_ROUND : S_MAC;
      end
      S_MAC: begin
        if (sts.tap_last) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        cmd.load  = s_tvalid;
      end
      S_READ: begin
        cmd.rd   = 1'b1;
        cmd.init = 1'b1;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
      end
      S_ROUND: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/apf_dp.sv @@
// Datapath with the history memory, the shared multiply-accumulate and the output register.
module apf_dp #(
  parameter int MAX_ORDER = apf_pkg::MAX_ORDER_DEF,
  parameter int CHANNELS  = apf_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  apf_pkg::cmd_t                     cmd,
  output apf_pkg::sts_t                     sts,
  input  logic [apf_pkg::TDATA_W-1:0]       s_tdata,
  input  logic                              s_tuser,
  input  logic [apf_pkg::ORDER_W-1:0]       filter_order,
  input  apf_pkg::coef_t                    coef [apf_pkg::NUM_COEF],
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [apf_pkg::TDATA_W-1:0]       m_tdata,
  output logic                              m_tuser
);

  import apf_pkg::*;

  localparam int ROW_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ROW_BITS = MAX_ORDER * SAMPLE_W;
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-32768);
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1 << (FRAC_SHIFT - 1));

  function automatic logic [ROW_W-1:0] row_of(input logic [CHAN_W-1:0] c);
    logic [15:0] r;
    r = 16'(c);
    for (int b = CHAN_W - 1; b >= 0; b--) begin
      if (r >= (16'(CHANNELS) << b)) r = r - (16'(CHANNELS) << b);
    end
    return r[ROW_W-1:0];
  endfunction

  logic [CHAN_W-1:0]          chan_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       restart_q;
  logic [ROW_W-1:0]           row_q;
  logic signed [ACC_W-1:0]    acc;
  logic [TAP_W-1:0]           tap;
  logic [ROW_W-1:0]           clr_cnt;
  logic [CHAN_W-1:0]          out_chan;
  logic [SAMPLE_W-1:0]        out_y;
  logic                       out_sat;

  logic [ROW_BITS-1:0]        rd_row;
  logic [ROW_BITS-1:0]        new_row;
  logic                       wr_en;
  logic [ROW_W-1:0]           wr_addr;
  logic [ROW_BITS-1:0]        wr_data;
  logic signed [SAMPLE_W-1:0] hist [MAX_ORDER];
  coef_t                      coef_l [MAX_ORDER];
  logic signed [2*SAMPLE_W-1:0] prod;
  logic [ORDER_W-1:0]         order_eff;
  logic signed [ACC_W-1:0]    rsum;
  logic signed [ACC_W-1:0]    yfull;
  logic [SAMPLE_W-1:0]        y;
  logic                       y_sat;

  apf_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(CHANNELS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (row_q),
    .rd_data (rd_row)
  );

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_lane
    assign hist[i]   = restart_q ? '0 : rd_row[i*SAMPLE_W +: SAMPLE_W];
    assign coef_l[i] = coef[i];
    if (i == 0) begin : g_first
      assign new_row[SAMPLE_W-1:0] = y;
    end else begin : g_rest
      assign new_row[i*SAMPLE_W +: SAMPLE_W] = hist[i-1];
    end
  end

  assign order_eff = (filter_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : filter_order;
  assign prod      = coef_l[tap] * hist[tap];

  assign rsum  = acc + HALF;
  assign yfull = rsum >>> FRAC_SHIFT;

  always_comb begin
    y     = yfull[SAMPLE_W-1:0];
    y_sat = 1'b0;
    if (yfull > Y_MAX) begin
      y     = 16'h7fff;
      y_sat = 1'b1;
    end else if (yfull < Y_MIN) begin
      y     = 16'h8000;
      y_sat = 1'b1;
    end
  end

  assign wr_en   = cmd.clr_wr | cmd.finish;
  assign wr_addr = cmd.clr_wr ? clr_cnt : row_q;
  assign wr_data = cmd.clr_wr ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_q    <= s_tdata[CHAN_W-1:0];
      x_q       <= s_tdata[CHAN_W +: SAMPLE_W];
      restart_q <= s_tuser;
      row_q     <= row_of(s_tdata[CHAN_W-1:0]);
    end
    if (cmd.init) begin
      acc <= {{(ACC_W-SAMPLE_W-FRAC_SHIFT){x_q[SAMPLE_W-1]}}, x_q, FRAC_SHIFT'(0)};
      tap <= '0;
    end else if (cmd.mac) begin
      acc <= acc - ACC_W'(prod);
      tap <= tap + TAP_W'(1);
    end
    if (cmd.finish) begin
      out_chan <= chan_q;
      out_y    <= y;
      out_sat  <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + ROW_W'(1);
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign sts.clr_last   = (clr_cnt == ROW_W'(CHANNELS - 1));
  assign sts.order_zero = (order_eff == '0);
  assign sts.tap_last   = ((ORDER_W'(tap) + ORDER_W'(1)) == order_eff);
  assign sts.out_free   = !m_tvalid || m_tready;

  assign m_tdata = {(TDATA_W-CHAN_W-SAMPLE_W)'(0), out_y, out_chan};
  assign m_tuser = out_sat;

endmodule

@@ hdl/all_pole_iir_filter.sv @@
// Top level of the multi-channel all-pole IIR filter with its register port.
// Samples of up to CHANNELS interleaved signals arrive on the s_t* stream; each
// transfer carries a channel number, a Q1.15 sample and a restart flag in tuser.
// Restart clears that channel's output history before the sample is filtered.
// The filter computes y = x - sum a_k * y[n-k] over filter_order taps, rounds to
// Q1.15 and saturates; tuser on the m_t* stream reports the clipping.
// Coefficients and the order must be written over the APB port only while the
// block idles; the block itself does not enforce this. Each item passes through
// accept, history read, one multiply-accumulate step per tap on the shared
// multiplier (none when filter_order, capped at MAX_ORDER, is zero) and round,
// which writes back and loads the output register; a new sample is accepted
// only once the previous one has left round. After reset a clearing pass zeroes
// every history row, with s_tready low. When the receiver stalls, the result
// holds in the output register, the next item is still accepted and computed,
// and it waits in its rounding step until the output register is free.
module all_pole_iir_filter #(
  parameter int MAX_ORDER = apf_pkg::MAX_ORDER_DEF,
  parameter int CHANNELS  = apf_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [apf_pkg::TDATA_W-1:0]  s_tdata,   // channel[5:0], sample_in[21:6], zero pad
  input  logic                         s_tuser,   // restart[0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [apf_pkg::TDATA_W-1:0]  m_tdata,   // out_channel[5:0], sample_out[21:6], zero pad
  output logic                         m_tuser,   // saturated[0]
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apf_pkg::ADDR_W-1:0]   paddr,
  input  logic [apf_pkg::PDATA_W-1:0]  pwdata,
  output logic [apf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import apf_pkg::*;

  logic [ORDER_W-1:0] filter_order;
  coef_t              coef [NUM_COEF];
  reg_idx_t           reg_idx;
  logic               reg_wr;
  cmd_t               cmd;
  sts_t               sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= '0;
      for (int i = 0; i < NUM_COEF; i++) coef[i] <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_ORDER: filter_order <= pwdata[ORDER_W-1:0];
        REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4, REG_COEF5, REG_COEF6: begin
          coef[reg_idx - REG_COEF1] <= pwdata[SAMPLE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORDER: prdata = PDATA_W'(filter_order);
      REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4, REG_COEF5, REG_COEF6: begin
        prdata = PDATA_W'(coef[reg_idx - REG_COEF1]);
        prdata[PDATA_W-1:SAMPLE_W] = '0;
      end
      default: prdata = '0;
    endcase
  end

  apf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  apf_dp #(
    .MAX_ORDER (MAX_ORDER),
    .CHANNELS  (CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .filter_order (filter_order),
    .coef         (coef),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

  assign s_tready = cmd.ready;

endmodule

@@ hdl/apf_checker.sv @@
// Port-level checker for the all-pole filter and its bind to the top level.
`include "assert_macros.svh"

module apf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [apf_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tuser
);

  `APF_ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output transfer changed")
  `APF_ASSERT_RST(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready, "input accepted while a sample is in work")
  `APF_ASSERT_RST(a_sat_value, clk, rst, m_tvalid && m_tuser |-> m_tdata[21:6] == 16'h7fff || m_tdata[21:6] == 16'h8000, "saturation flag without a clipped value")
  `APF_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !s_tready && !m_tvalid, "block active right after reset")

endmodule

bind all_pole_iir_filter apf_checker u_apf_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the all-pole IIR filter: a directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import apf_pkg::*;

  localparam int REG_UNUSED    = 7;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] y;
    logic                       sat;
  } filtered_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    int                         idx;
    logic [PDATA_W-1:0]         word;
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] x;
    logic                       rs;
    logic                       known;
    logic signed [SAMPLE_W-1:0] y;
    logic                       sat;
  } stim_row_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TDATA_W-1:0]   s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tuser;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ADDR_W-1:0]    paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic [ORDER_W-1:0]         order_reg;
  logic signed [SAMPLE_W-1:0] coef_reg [1:NUM_COEF];
  logic signed [SAMPLE_W-1:0] output_hist [CHANNELS_DEF][MAX_ORDER_DEF];

  filtered_t pending_outputs [$];
  stim_row_t directed_rows [$];

  logic sender_idle = 1'b1;
  logic sink_idle   = 1'b1;
  logic hold_output = 1'b0;
  int   samples_sent    = 0;
  int   outputs_checked = 0;
  int   saturated_seen  = 0;
  int   mismatches      = 0;
  int   cycle_count     = 0;

  all_pole_iir_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic filtered_t compute_filter_output(input logic [CHAN_W-1:0] ch,
                                                      input logic signed [SAMPLE_W-1:0] x,
                                                      input logic rs);
    filtered_t r;
    int        taps;
    longint    acc;
    taps = (order_reg > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(order_reg);
    if (rs) begin
      for (int k = 0; k < MAX_ORDER_DEF; k++) output_hist[ch][k] = '0;
    end
    acc = longint'(x) <<< FRAC_SHIFT;
    for (int k = 0; k < taps; k++) begin
      acc -= longint'(coef_reg[k+1]) * longint'(output_hist[ch][k]);
    end
    acc = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    r.chan = ch;
    r.sat  = 1'b0;
    if (acc > 32767) begin
      acc   = 32767;
      r.sat = 1'b1;
    end else if (acc < -32768) begin
      acc   = -32768;
      r.sat = 1'b1;
    end
    r.y = acc[SAMPLE_W-1:0];
    for (int k = MAX_ORDER_DEF - 1; k > 0; k--) output_hist[ch][k] = output_hist[ch][k-1];
    output_hist[ch][0] = r.y;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input int idx, input int value);
    stim_row_t r;
    r = '{ROW_WRITE, idx, PDATA_W'(value), '0, '0, 1'b0, 1'b0, '0, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t sample_row(input int ch, input int x, input bit rs);
    stim_row_t r;
    r = '{ROW_SAMPLE, 0, '0, CHAN_W'(ch), SAMPLE_W'(x), rs, 1'b0, '0, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t known_row(input int ch, input int x, input bit rs,
                                          input int y, input bit sat);
    stim_row_t r;
    r = '{ROW_SAMPLE, 0, '0, CHAN_W'(ch), SAMPLE_W'(x), rs, 1'b1, SAMPLE_W'(y), sat};
    return r;
  endfunction

  task automatic apb_write(input int idx, input logic [PDATA_W-1:0] word);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(idx * 4);
    pwdata  = word;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_ORDER) begin
      order_reg = word[ORDER_W-1:0];
    end else if (idx >= REG_COEF1 && idx <= REG_COEF6) begin
      coef_reg[idx] = word[SAMPLE_W-1:0];
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x,
                             input logic rs, input logic known,
                             input logic signed [SAMPLE_W-1:0] y, input logic sat);
    int        gap;
    filtered_t want;
    gap = sender_idle ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, x, ch};
    s_tuser  = rs;
    do @(posedge clk); while (!s_tready);
    want = compute_filter_output(ch, x, rs);
    if (known) begin
      want.y   = y;
      want.sat = sat;
    end
    pending_outputs.push_back(want);
    samples_sent++;
  endtask

  task automatic wait_for_outputs();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  // Output side: random back-pressure, plus one long hold while the input keeps coming.
  initial begin
    int wait_cycles;
    forever begin
      if (hold_output) begin
        @(negedge clk);
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      wait_cycles = sink_idle ? $urandom_range(0, 14) : 0;
      repeat (wait_cycles) begin
        @(negedge clk);
        m_tready = 1'b0;
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_outputs
    filtered_t want;
    if (!rst && m_tvalid && m_tready) begin
      outputs_checked++;
      if (m_tuser) saturated_seen++;
      if (pending_outputs.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("Unexpected transfer: chan %0d sample %0d sat %0b",
                   m_tdata[5:0], $signed(m_tdata[21:6]), m_tuser);
        mismatches++;
      end else begin
        want = pending_outputs.pop_front();
        if (m_tdata[5:0] !== want.chan || m_tdata[21:6] !== want.y ||
            m_tuser !== want.sat || m_tdata[23:22] !== 2'b00) begin
          if (mismatches < REPORT_MAX)
            $display("Mismatch: expected chan %0d sample %0d sat %0b, got chan %0d sample %0d sat %0b pad %b",
                     want.chan, want.y, want.sat, m_tdata[5:0], $signed(m_tdata[21:6]),
                     m_tuser, m_tdata[23:22]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout with %0d outputs outstanding.", pending_outputs.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int                         order_pick;
    int                         coef;
    int                         hot_base;
    logic                       wild;
    logic [PDATA_W-1:0]         word;
    logic [CHAN_W-1:0]          ch;
    logic signed [SAMPLE_W-1:0] x;

    order_reg = '0;
    for (int k = 1; k <= NUM_COEF; k++) coef_reg[k] = '0;
    for (int c = 0; c < CHANNELS_DEF; c++)
      for (int k = 0; k < MAX_ORDER_DEF; k++) output_hist[c][k] = '0;

    directed_rows.push_back(known_row(0, 32767, 0, 32767, 0));
    directed_rows.push_back(known_row(63, -32768, 0, -32768, 0));
    directed_rows.push_back(known_row(42, 0, 0, 0, 0));
    directed_rows.push_back(known_row(21, 1, 1, 1, 0));
    directed_rows.push_back(reg_row(REG_ORDER, 1));
    directed_rows.push_back(reg_row(REG_COEF1, -8192));
    directed_rows.push_back(known_row(5, 20000, 1, 20000, 0));
    directed_rows.push_back(known_row(5, 20000, 0, 32767, 1));
    directed_rows.push_back(known_row(5, -32768, 0, -1, 0));
    directed_rows.push_back(known_row(5, -32768, 1, -32768, 0));
    directed_rows.push_back(known_row(5, -32768, 0, -32768, 1));
    directed_rows.push_back(reg_row(REG_COEF1, 4096));
    directed_rows.push_back(known_row(9, 1, 1, 1, 0));
    directed_rows.push_back(known_row(9, 0, 0, 0, 0));
    directed_rows.push_back(known_row(9, 3, 1, 3, 0));
    directed_rows.push_back(known_row(9, 0, 0, -1, 0));
    directed_rows.push_back(known_row(9, 0, 0, 1, 0));
    directed_rows.push_back(reg_row(REG_ORDER, 7));
    for (int k = REG_COEF1; k <= REG_COEF6; k++) directed_rows.push_back(reg_row(k, -32768));
    directed_rows.push_back(reg_row(REG_UNUSED, 5));
    directed_rows.push_back(known_row(63, 32767, 1, 32767, 0));
    directed_rows.push_back(sample_row(63, -32768, 0));
    directed_rows.push_back(sample_row(63, 0, 0));
    directed_rows.push_back(reg_row(REG_ORDER, 6));
    for (int k = REG_COEF1; k <= REG_COEF6; k++) directed_rows.push_back(reg_row(k, 32767));
    directed_rows.push_back(sample_row(5, 1000, 0));
    directed_rows.push_back(sample_row(5, -1000, 0));
    directed_rows.push_back(sample_row(9, -32768, 0));
    directed_rows.push_back(sample_row(42, 12345, 1));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    do @(posedge clk); while (!s_tready);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_for_outputs();
        apb_write(directed_rows[i].idx, directed_rows[i].word);
      end else begin
        send_sample(directed_rows[i].chan, directed_rows[i].x, directed_rows[i].rs,
                    directed_rows[i].known, directed_rows[i].y, directed_rows[i].sat);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_outputs();
      if (p == 0) begin
        order_pick = 0;
      end else if (p == 1) begin
        order_pick = 7;
      end else if (p == 2) begin
        order_pick = MAX_ORDER_DEF;
      end else begin
        order_pick = $urandom_range(0, 7);
      end
      wild = (p == 1) || (p >= 3 && p % 2 == 1);
      word = $urandom();
      word[ORDER_W-1:0] = order_pick[ORDER_W-1:0];
      apb_write(REG_ORDER, word);
      for (int k = REG_COEF1; k <= REG_COEF6; k++) begin
        if (p == 2) begin
          coef = (k % 2 == 1) ? 32767 : -32768;
        end else if (wild) begin
          coef = $urandom_range(0, 65535);
        end else begin
          coef = int'($urandom_range(0, 2047)) - 1024;
        end
        word = $urandom();
        word[SAMPLE_W-1:0] = coef[SAMPLE_W-1:0];
        apb_write(k, word);
      end
      apb_write(REG_UNUSED, $urandom());

      sender_idle = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      if (p == 2) hold_output = 1'b1;
      hot_base = $urandom_range(0, CHANNELS_DEF - 4);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          ch = CHAN_W'(hot_base + $urandom_range(0, 3));
        end else begin
          ch = CHAN_W'($urandom_range(0, CHANNELS_DEF - 1));
        end
        if ($urandom_range(0, 1) != 0) begin
          x = SAMPLE_W'($urandom_range(0, 65535));
        end else begin
          x = SAMPLE_W'(int'($urandom_range(0, 2047)) - 1024);
        end
        send_sample(ch, x, $urandom_range(0, 15) == 0, 1'b0, '0, 1'b0);
      end
    end

    wait_for_outputs();
    repeat (16) @(posedge clk);

    $display("Sent %0d samples through %0d register settings; %0d outputs checked, %0d saturated.",
             samples_sent, RANDOM_PHASES + 4, outputs_checked, saturated_seen);
    $display("Mismatches: %0d, outputs still outstanding: %0d.", mismatches,
             pending_outputs.size());
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
